// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the top level and sbrp_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property holds at every clock edge outside reset
`define SBRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbrp assertion failed");
// expression never true at a clock edge outside reset
`define SBRP_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sbrp forbidden condition seen");
`else
`define SBRP_ASSERT(lbl, clk, rst_n, prop)
`define SBRP_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- hw/rtl/sbrp_pkg.sv -----
// types, constants and functions of the sensor bus response parser
`default_nettype none

package sbrp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 255;
  // position counter saturates at MAX_FRAME_BYTES + 1, past the last byte that is taken
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
  // wide enough for positions and for 12 + payload length
  localparam int unsigned CMP_W = 10;

  localparam logic [7:0]  BYTE_SOH = 8'h01;
  localparam logic [7:0]  BYTE_VER = 8'h10;
  localparam logic [7:0]  BYTE_STX = 8'h02;
  localparam logic [7:0]  BYTE_ETX = 8'h03;
  localparam logic [7:0]  BYTE_EOT = 8'h04;
  localparam logic [7:0]  CMD_ONLINE = 8'h23;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam int unsigned POS_SOH  = 0;
  localparam int unsigned POS_VER  = 1;
  localparam int unsigned POS_LEN  = 6;
  localparam int unsigned POS_STX  = 7;
  localparam int unsigned POS_CMD  = 8;
  localparam int unsigned POS_STAT = 10;
  localparam int unsigned POS_CHL  = 11;
  localparam int unsigned POS_CHH  = 12;
  localparam int unsigned POS_TYPE = 13;
  localparam int unsigned POS_VAL  = 14;
  localparam int unsigned VAL_BYTES = 8;

  localparam int unsigned FRAME_OVERHEAD = 12;
  localparam int unsigned MIN_FRAME_BYTES = 15;
  localparam int unsigned MAX_PAYLOAD = 243;
  localparam int unsigned PAYLOAD_HDR = 6;

  typedef enum logic [2:0] {
    CODE_OK     = 3'd0,
    CODE_FRAME  = 3'd1,
    CODE_CRC    = 3'd2,
    CODE_CMD    = 3'd3,
    CODE_STATUS = 3'd4,
    CODE_TYPE   = 3'd5
  } res_code_t;

  typedef struct packed {
    res_code_t   code;
    logic [7:0]  status;
    logic [15:0] channel;
    logic [7:0]  vtype;
    logic [63:0] raw;
  } res_t;

  // reflected crc-16, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // value length in bytes for a type code, zero when unknown
  function automatic logic [3:0] value_len(input logic [7:0] t);
    logic [3:0] vl;
    case (t)
      8'h10, 8'h11:        vl = 4'd1;
      8'h12, 8'h13:        vl = 4'd2;
      8'h14, 8'h15, 8'h16: vl = 4'd4;
      8'h17:               vl = 4'd8;
      default:             vl = 4'd0;
    endcase
    return vl;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sensor_bus_response_parser.sv -----
// top level: input register, frame parser core and result register
// a last byte waits in the input register until the result register is free, then its result is registered there
// throughput: one byte per cycle; set by the single-byte crc update in sbrp_core
// a waiting result only holds back a last byte; other bytes keep flowing
// reset: synchronous active-low rst_n empties both registers and restarts the frame
`default_nettype none
`include "assert_macros.svh"

module sensor_bus_response_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_code,
  output logic [7:0]       out_meas_status,
  output logic [15:0]      out_channel_number,
  output logic [7:0]       out_value_type,
  output logic [63:0]      out_raw_value
);
  import sbrp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       core_res;
  logic       out_free, step, in_xfer;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !step;
  assign in_xfer  = in_valid && !in_stall;

  sbrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_code    = out_res_r.code;
  assign out_meas_status    = out_res_r.status;
  assign out_channel_number = out_res_r.channel;
  assign out_value_type     = out_res_r.vtype;
  assign out_raw_value      = out_res_r.raw;

  `SBRP_NEVER(a_stall_only_when_busy, clk, rst_n, in_stall && !s1_valid_r)
  `SBRP_NEVER(a_raw_zero_unless_ok, clk, rst_n, out_valid_r && out_res_r.code != CODE_OK && out_res_r.raw != 64'h0)
  `SBRP_ASSERT(a_last_byte_makes_result, clk, rst_n, (step && s1_last_r) |=> out_valid_r)
  `SBRP_NEVER(a_no_overwrite, clk, rst_n, step && s1_last_r && out_valid_r && out_stall)

endmodule

`default_nettype wire

// ----- hw/rtl/sbrp_core.sv -----
// frame state, crc and result decision for one byte per step
`default_nettype none
`include "assert_macros.svh"

module sbrp_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output sbrp_pkg::res_t     res
);
  import sbrp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       plen_r, plen_nxt;
  logic             fok_r, fok_nxt;
  logic [15:0]      rcrc_r, rcrc_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       stat_r, stat_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [63:0]      val_r, val_nxt;

  logic [CMP_W-1:0] p_ext, tot, tot_n, len;
  logic             take, frame_err;
  logic [3:0]       vl;
  logic [63:0]      raw_masked;

  // next state for the byte at the current position
  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    plen_nxt = plen_r;
    fok_nxt  = fok_r;
    rcrc_nxt = rcrc_r;
    cmd_nxt  = cmd_r;
    stat_nxt = stat_r;
    chan_nxt = chan_r;
    type_nxt = type_r;
    val_nxt  = val_r;
    p_ext = CMP_W'(pos_r);
    tot   = CMP_W'(plen_r) + CMP_W'(FRAME_OVERHEAD);
    take  = pos_r < POS_W'(MAX_FRAME_BYTES);
    if (take) begin
      if (p_ext <= tot - CMP_W'(4)) crc_nxt = crc_update(crc_r, data_byte);
      if (p_ext == CMP_W'(POS_SOH) && data_byte != BYTE_SOH) fok_nxt = 1'b0;
      if (p_ext == CMP_W'(POS_VER) && data_byte != BYTE_VER) fok_nxt = 1'b0;
      if (p_ext == CMP_W'(POS_LEN)) plen_nxt = data_byte;
      if (p_ext == CMP_W'(POS_STX) && data_byte != BYTE_STX) fok_nxt = 1'b0;
      if (p_ext == CMP_W'(POS_CMD)) cmd_nxt = data_byte;
      if (p_ext >= CMP_W'(POS_CMD)) begin
        if (p_ext == tot - CMP_W'(4) && data_byte != BYTE_ETX) fok_nxt = 1'b0;
        if (p_ext == tot - CMP_W'(1) && data_byte != BYTE_EOT) fok_nxt = 1'b0;
        if (p_ext == tot - CMP_W'(3)) rcrc_nxt[7:0] = data_byte;
        if (p_ext == tot - CMP_W'(2)) rcrc_nxt[15:8] = data_byte;
      end
      if (p_ext == CMP_W'(POS_STAT)) stat_nxt = data_byte;
      if (p_ext == CMP_W'(POS_CHL)) chan_nxt[7:0] = data_byte;
      if (p_ext == CMP_W'(POS_CHH)) chan_nxt[15:8] = data_byte;
      if (p_ext == CMP_W'(POS_TYPE)) type_nxt = data_byte;
      for (int k = 0; k < VAL_BYTES; k++) begin
        if (p_ext == CMP_W'(POS_VAL + k)) val_nxt[8*k +: 8] = data_byte;
      end
    end
    if (pos_r <= POS_W'(MAX_FRAME_BYTES)) pos_nxt = pos_r + POS_W'(1);
  end

  // result as seen after this byte, used only when it is the last one
  always_comb begin
    tot_n = CMP_W'(plen_nxt) + CMP_W'(FRAME_OVERHEAD);
    len   = p_ext + CMP_W'(1);
    vl    = value_len(type_nxt);
    frame_err = (len < CMP_W'(MIN_FRAME_BYTES)) || (len > CMP_W'(MAX_FRAME_BYTES)) ||
                (plen_nxt > 8'(MAX_PAYLOAD)) || !fok_nxt || (tot_n > len);
    case (vl)
      4'd1:    raw_masked = {56'h0, val_nxt[7:0]};
      4'd2:    raw_masked = {48'h0, val_nxt[15:0]};
      4'd4:    raw_masked = {32'h0, val_nxt[31:0]};
      default: raw_masked = val_nxt;
    endcase
    res = '{code: CODE_OK, status: 8'h00, channel: 16'h0000, vtype: 8'h00, raw: 64'h0};
    if (frame_err) begin
      res.code = CODE_FRAME;
    end else if (crc_nxt != rcrc_nxt) begin
      res.code = CODE_CRC;
    end else if (cmd_nxt != CMD_ONLINE) begin
      res.code = CODE_CMD;
    end else begin
      res.status  = stat_nxt;
      res.channel = chan_nxt;
      if (stat_nxt != 8'h00) begin
        res.code = CODE_STATUS;
      end else begin
        res.vtype = type_nxt;
        if (vl == 4'd0) begin
          res.code = CODE_TYPE;
        end else if ({1'b0, plen_nxt} < 9'(PAYLOAD_HDR) + {5'h00, vl}) begin
          res.code = CODE_FRAME;
        end else begin
          res.raw = raw_masked;
        end
      end
    end
  end

  // reset or the last byte of a buffer returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      plen_r <= 8'h00;
      fok_r  <= 1'b1;
      rcrc_r <= 16'h0000;
      cmd_r  <= 8'h00;
      stat_r <= 8'h00;
      chan_r <= 16'h0000;
      type_r <= 8'h00;
      val_r  <= 64'h0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      plen_r <= plen_nxt;
      fok_r  <= fok_nxt;
      rcrc_r <= rcrc_nxt;
      cmd_r  <= cmd_nxt;
      stat_r <= stat_nxt;
      chan_r <= chan_nxt;
      type_r <= type_nxt;
      val_r  <= val_nxt;
    end
  end

  `SBRP_ASSERT(a_restart_after_last, clk, rst_n, (step && last_byte) |=> (pos_r == '0 && crc_r == CRC_INIT && fok_r))
  `SBRP_NEVER(a_pos_saturates, clk, rst_n, pos_r > POS_W'(MAX_FRAME_BYTES + 1))
  `SBRP_NEVER(a_early_fail_no_fields, clk, rst_n, step && (res.code == CODE_CRC || res.code == CODE_CMD) && (res.status != 8'h00 || res.channel != 16'h0000))

endmodule

`default_nettype wire

// ----- dv/sensor_bus_response_parser_tb.sv -----
// testbench for the sensor bus response parser: framed byte stimulus, scoreboard, random stalls
module sensor_bus_response_parser_tb;
  import sbrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;
  typedef enum {FLAW_BIT, FLAW_TRUNCATE, FLAW_TRAILING, FLAW_CRC, FLAW_HEADER,
                FLAW_ETX, FLAW_EOT, FLAW_LENGTH} flaw_t;

  class parse_scoreboard;
    int unsigned pos;
    logic [15:0] crc;
    logic [7:0]  plen;
    bit          framing_ok;
    logic [15:0] rx_crc;
    logic [7:0]  cmd;
    logic [7:0]  status;
    logic [15:0] chan;
    logic [7:0]  vtype;
    logic [63:0] value;
    res_t        expected_results[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
    endfunction

    function void restart();
      pos = 0;
      crc = 16'hFFFF;
      plen = '0;
      framing_ok = 1'b1;
      rx_crc = '0;
      cmd = '0;
      status = '0;
      chan = '0;
      vtype = '0;
      value = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // predicts the parser state after one accepted byte transfer
    function void note_byte(logic [7:0] b, bit last);
      int unsigned p, total, blen, vl;
      res_t r;
      p = pos;
      if (p < MAX_FRAME_BYTES) begin
        total = FRAME_OVERHEAD + plen;
        if (p <= total - 4) crc = crc_step(crc, b);
        if (p == POS_SOH && b != BYTE_SOH) framing_ok = 1'b0;
        if (p == POS_VER && b != BYTE_VER) framing_ok = 1'b0;
        if (p == POS_LEN) plen = b;
        if (p == POS_STX && b != BYTE_STX) framing_ok = 1'b0;
        if (p == POS_CMD) cmd = b;
        if (p >= POS_CMD) begin
          if (p == total - 4 && b != BYTE_ETX) framing_ok = 1'b0;
          if (p == total - 1 && b != BYTE_EOT) framing_ok = 1'b0;
          if (p == total - 3) rx_crc[7:0] = b;
          if (p == total - 2) rx_crc[15:8] = b;
        end
        if (p == POS_STAT) status = b;
        if (p == POS_CHL) chan[7:0] = b;
        if (p == POS_CHH) chan[15:8] = b;
        if (p == POS_TYPE) vtype = b;
        if (p >= POS_VAL && p < POS_VAL + VAL_BYTES) value |= 64'(b) << (8 * (p - POS_VAL));
      end
      if (p <= MAX_FRAME_BYTES) pos = p + 1;
      if (!last) return;

      blen = p + 1;
      total = FRAME_OVERHEAD + plen;
      r = '0;
      r.code = CODE_OK;
      case (vtype)
        8'h10, 8'h11:        vl = 1;
        8'h12, 8'h13:        vl = 2;
        8'h14, 8'h15, 8'h16: vl = 4;
        8'h17:               vl = 8;
        default:             vl = 0;
      endcase
      if (blen < MIN_FRAME_BYTES || blen > MAX_FRAME_BYTES || plen > MAX_PAYLOAD ||
          !framing_ok || total > blen) begin
        r.code = CODE_FRAME;
      end else if (crc != rx_crc) begin
        r.code = CODE_CRC;
      end else if (cmd != CMD_ONLINE) begin
        r.code = CODE_CMD;
      end else begin
        r.status = status;
        r.channel = chan;
        if (status != 8'h00) begin
          r.code = CODE_STATUS;
        end else begin
          r.vtype = vtype;
          if (vl == 0) begin
            r.code = CODE_TYPE;
          end else if (plen < PAYLOAD_HDR + vl) begin
            r.code = CODE_FRAME;
          end else if (vl >= 8) begin
            r.raw = value;
          end else begin
            r.raw = value & ((64'd1 << (8 * vl)) - 64'd1);
          end
        end
      end
      expected_results.push_back(r);
      restart();
    endfunction

    function void check_result(logic [2:0] code, logic [7:0] st, logic [15:0] ch,
                               logic [7:0] ty, logic [63:0] raw);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with none expected: code %0d", code);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (e.code != code) begin
        $error("result_code: expected %0d, got %0d", e.code, code);
        errors++;
      end
      if (e.status != st) begin
        $error("meas_status: expected %h, got %h", e.status, st);
        errors++;
      end
      if (e.channel != ch) begin
        $error("channel_number: expected %h, got %h", e.channel, ch);
        errors++;
      end
      if (e.vtype != ty) begin
        $error("value_type: expected %h, got %h", e.vtype, ty);
        errors++;
      end
      if (e.raw != raw) begin
        $error("raw_value: expected %h, got %h", e.raw, raw);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_result_code;
  logic [7:0]  out_meas_status;
  logic [15:0] out_channel_number;
  logic [7:0]  out_value_type;
  logic [63:0] out_raw_value;

  parse_scoreboard sb;
  logic [7:0]      frame[$];
  int              burst_left = 0;
  int              bytes_sent = 0;
  int              frames_sent = 0;
  bit              hold_request = 1'b0;
  int unsigned     cycle_count = 0;

  sensor_bus_response_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_code    (out_result_code),
    .out_meas_status    (out_meas_status),
    .out_channel_number (out_channel_number),
    .out_value_type     (out_value_type),
    .out_raw_value      (out_raw_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // well-formed frame with the given payload fields, crc computed over soh..etx
  function automatic void build_frame(int plen, logic [7:0] cmd, logic [7:0] st,
                                      logic [7:0] vt, logic [63:0] value);
    logic [15:0] c;
    frame.delete();
    frame.push_back(BYTE_SOH);
    frame.push_back(BYTE_VER);
    repeat (4) frame.push_back(8'($urandom_range(0, 255)));
    frame.push_back(plen[7:0]);
    frame.push_back(BYTE_STX);
    for (int i = 0; i < plen; i++) begin
      case (i)
        0:       frame.push_back(cmd);
        2:       frame.push_back(st);
        5:       frame.push_back(vt);
        default: begin
          if (i >= 6 && i < 14) frame.push_back(value[8 * (i - 6) +: 8]);
          else frame.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    frame.push_back(BYTE_ETX);
    c = 16'hFFFF;
    foreach (frame[i]) c = parse_scoreboard::crc_step(c, frame[i]);
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    frame.push_back(BYTE_EOT);
  endfunction

  function automatic void spoil_frame(flaw_t flaw);
    int n;
    int idx;
    n = frame.size();
    case (flaw)
      FLAW_BIT:      frame[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
      FLAW_TRUNCATE: repeat ($urandom_range(1, n - 1)) void'(frame.pop_back());
      FLAW_TRAILING: repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
      FLAW_CRC:      frame[n - 3] ^= 8'($urandom_range(1, 255));
      FLAW_HEADER: begin
        idx = $urandom_range(0, 2);
        idx = (idx == 0) ? POS_SOH : (idx == 1) ? POS_VER : POS_STX;
        frame[idx] ^= 8'($urandom_range(1, 255));
      end
      FLAW_ETX:      frame[n - 4] ^= 8'($urandom_range(1, 255));
      FLAW_EOT:      frame[n - 1] ^= 8'($urandom_range(1, 255));
      FLAW_LENGTH:   frame[POS_LEN] = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    int plen;
    logic [7:0] cmd, st, vt;
    plen = $urandom_range(7, 16);
    if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 30);
    if ($urandom_range(0, 49) == 0) plen = $urandom_range(200, MAX_PAYLOAD);
    cmd = ($urandom_range(0, 9) != 0) ? CMD_ONLINE : 8'($urandom_range(0, 255));
    st = ($urandom_range(0, 6) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
    vt = ($urandom_range(0, 9) != 0) ? 8'(8'h10 + $urandom_range(0, 7))
                                     : 8'($urandom_range(0, 255));
    build_frame(plen, cmd, st, vt, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) spoil_frame(flaw_t'($urandom_range(0, 7)));
    send_frame();
  endtask

  // receiver: checks result transfers and stalls in changing modes
  initial begin
    int hold_left;
    int mode_left;
    stall_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    mode = STALL_NONE;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_result_code, out_meas_status, out_channel_number,
                        out_value_type, out_raw_value);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_SOME:  out_stall <= ($urandom_range(0, 2) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every type code, all-ones and all-zero values
    for (int t = 0; t < 8; t++) begin
      build_frame(t == 7 ? 14 : 10, CMD_ONLINE, 8'h00, 8'(8'h10 + t),
                  (t % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0);
      send_frame();
    end
    build_frame(13, 8'h00, 8'h00, 8'h10, 64'h5A);          // other command
    send_frame();
    build_frame(13, CMD_ONLINE, 8'hFF, 8'h10, 64'h5A);     // nonzero status
    send_frame();
    build_frame(13, CMD_ONLINE, 8'h00, 8'h00, 64'h5A);     // unknown type, low
    send_frame();
    build_frame(13, CMD_ONLINE, 8'h00, 8'hFF, 64'h5A);     // unknown type, high
    send_frame();
    build_frame(10, CMD_ONLINE, 8'h00, 8'h17, '1);         // payload too short for value
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    frame[POS_SOH] = 8'h00;
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    frame[POS_VER] = 8'hFF;
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    frame[POS_STX] = 8'h03;
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    spoil_frame(FLAW_ETX);
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    spoil_frame(FLAW_EOT);
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    spoil_frame(FLAW_CRC);
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    void'(frame.pop_back());                               // truncated frame
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    spoil_frame(FLAW_TRAILING);                            // bytes after the frame ignored
    send_frame();
    build_frame(2, CMD_ONLINE, 8'h00, 8'h10, '0);          // buffer shorter than minimum
    send_frame();
    frame.delete();
    frame.push_back(BYTE_SOH);                             // one-byte buffer
    send_frame();
    build_frame(9, CMD_ONLINE, 8'h00, 8'h12, '1);
    frame[POS_LEN] = 8'(MAX_PAYLOAD + 1);                  // oversized payload length
    send_frame();
    build_frame(MAX_PAYLOAD, CMD_ONLINE, 8'h00, 8'h17, 64'h0123_4567_89AB_CDEF);
    send_frame();                                          // largest legal frame
    build_frame(MAX_PAYLOAD, CMD_ONLINE, 8'h00, 8'h17, 64'h0123_4567_89AB_CDEF);
    repeat (5) frame.push_back(8'($urandom_range(0, 255))); // buffer past the limit
    send_frame();

    // random frames; a long receiver hold-off backs up the input once or twice
    bytes_sent = 0;
    frames_sent = 0;
    while (bytes_sent < 400) begin
      if (frames_sent == 5 || frames_sent == 25) hold_request = 1'b1;
      send_random_frame();
    end
    in_valid <= 1'b0;
    in_last_byte <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
